FILE: rtl/chained_hash_table_engine_core_defines.svh
// Assertion macros for the chained hash table engine
`ifndef CHAINED_HASH_TABLE_ENGINE_CORE_DEFINES_SVH
`define CHAINED_HASH_TABLE_ENGINE_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CHTE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CHTE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHTE_ASSERT(label, clk, rst_n, prop, msg)
`define CHTE_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

FILE: rtl/chte_pkg.sv
// Package: types, constants and codes of the chained hash table engine
`timescale 1ns / 1ps
package chte_pkg;
  localparam int unsigned Buckets     = 1024;
  localparam int unsigned Nodes       = 1024;
  localparam int unsigned PayloadBits = 64;
  localparam int unsigned BktW  = $clog2(Buckets);
  localparam int unsigned NodeW = $clog2(Nodes);
  localparam int unsigned CfgW  = 11;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0, OP_READ = 3'd1, OP_UPSERT = 3'd2, OP_UPDATE = 3'd3, OP_DELETE = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_NOT_FOUND = 2'd1, ST_PRESENT = 2'd2, ST_FULL = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [63:0] key;
    logic [63:0] payload;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] read_payload;
  } rsp_t;

  // request to the modulo unit and its answer
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
  } mod_req_t;

  typedef struct packed {
    logic            done;
    logic [BktW-1:0] bucket;
  } mod_rsp_t;
endpackage

FILE: rtl/chte_ram.sv
// Generic single-port-write, one-read synchronous RAM with registered read
`timescale 1ns / 1ps
module chte_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/chte_mod.sv
// Bit-serial restoring modulo: 32-bit dividend by the bucket count
`timescale 1ns / 1ps
module chte_mod (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  chte_pkg::mod_req_t    req_i,
  input  logic [chte_pkg::CfgW-1:0] divisor_i,
  output chte_pkg::mod_rsp_t    rsp_o
);
  import chte_pkg::*;

  logic [31:0]     dvd_q, dvd_d;
  logic [CfgW:0]   rem_q, rem_d;
  logic [5:0]      cnt_q, cnt_d;
  logic            run_q, run_d;
  logic            done_q, done_d;
  logic [CfgW:0]   trial;
  logic [CfgW-1:0] div_eff;

  // zero counts as one, values above the bucket total saturate
  always_comb begin
    div_eff = divisor_i;
    if (divisor_i == '0) div_eff = CfgW'(1);
    else if (divisor_i > CfgW'(Buckets)) div_eff = CfgW'(Buckets);
  end

  assign trial = {rem_q[CfgW-1:0], dvd_q[31]};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dvd_d = req_i.dividend;
      rem_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      dvd_d = {dvd_q[30:0], 1'b0};
      rem_d = (trial >= {1'b0, div_eff}) ? trial - {1'b0, div_eff} : trial;
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      rem_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      dvd_q  <= dvd_d;
      rem_q  <= rem_d;
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.bucket = rem_q[BktW-1:0];
endmodule

FILE: rtl/chained_hash_table_engine_core.sv
// Top level: chained hash table engine with node pool and free list
`timescale 1ns / 1ps
`include "chained_hash_table_engine_core_defines.svh"
// Chained hash table engine.
// Request channel: req_i is taken at a clock edge with start high and busy low.
// Operations: insert-if-absent, read, upsert, update, delete.
// Result channel: rsp_o is valid for exactly one cycle while done_o is high.
// The receiver cannot stall, so nothing ever holds a result back.
// Config: cfg_we_i writes the bucket count; only while idle, a rule the block does not enforce.
// Each request runs through these steps in order: the bucket modulo (32 restoring
// steps), the head read, then a registered read and a compare for each chain node.
// A delete hit then pushes the node on the free list. A miss that appends takes a
// node off the free list (reading its link first) or else from the fresh counter,
// writes it, and links it as head or behind the tail. An unknown op goes straight
// to the result. busy drops in the result cycle, so the next request can be taken
// at the edge that takes the result; the engine handles one request at a time.
// Reset: a clearing pass writes all Buckets head entries to zero, one a cycle
// with busy high; free list empty, fresh counter one.
module chained_hash_table_engine_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  chte_pkg::req_t            req_i,
  output logic                      done_o,
  output chte_pkg::rsp_t            rsp_o,
  input  logic                      cfg_we_i,
  input  logic [chte_pkg::CfgW-1:0] cfg_wdata_i
);
  import chte_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MOD, S_HEAD, S_NODE, S_CMP, S_FREE, S_FREERD, S_FREEWAIT,
    S_ALLOC, S_TAIL, S_DONE
  } state_e;

  state_e state_q;
  logic [CfgW-1:0]  bcnt_q;
  req_t             req_q;
  logic [BktW-1:0]  bkt_q, clr_q;
  logic [NodeW-1:0] pos_q, prev_q, free_q, newn_q;
  logic [NodeW:0]   fresh_q;
  logic [NodeW:0]   steps_q;
  rsp_t             rsp_q;
  logic             done_q;

  // memory ports
  logic             hd_we, k_we, v_we, l_we;
  logic [BktW-1:0]  hd_wa, hd_ra;
  logic [NodeW-1:0] hd_wd, hd_rd, l_wd, l_rd, k_wa, v_wa, l_wa, n_ra;
  logic [63:0]      k_rd, v_rd, k_wd, v_wd;

  mod_req_t mreq;
  mod_rsp_t mrsp;

  chte_mod u_mod (.clk_i, .rst_ni, .req_i(mreq), .divisor_i(bcnt_q), .rsp_o(mrsp));

  chte_ram #(.Width(NodeW), .Depth(Buckets)) u_head (
    .clk_i, .we_i(hd_we), .waddr_i(hd_wa), .wdata_i(hd_wd), .raddr_i(hd_ra), .rdata_o(hd_rd));
  chte_ram #(.Width(64), .Depth(Nodes)) u_key (
    .clk_i, .we_i(k_we), .waddr_i(k_wa), .wdata_i(k_wd), .raddr_i(n_ra), .rdata_o(k_rd));
  chte_ram #(.Width(64), .Depth(Nodes)) u_val (
    .clk_i, .we_i(v_we), .waddr_i(v_wa), .wdata_i(v_wd), .raddr_i(n_ra), .rdata_o(v_rd));
  chte_ram #(.Width(NodeW), .Depth(Nodes)) u_link (
    .clk_i, .we_i(l_we), .waddr_i(l_wa), .wdata_i(l_wd), .raddr_i(n_ra), .rdata_o(l_rd));

  localparam logic [63:0] PayMask = {64{1'b1}} >> (64 - PayloadBits);

  logic hit;
  assign hit = (k_rd == req_q.key);
  assign busy = (state_q != S_IDLE);

  // combinational memory controls
  always_comb begin
    mreq.start    = 1'b0;
    mreq.dividend = req_i.key[31:0];
    hd_we = 1'b0; hd_wa = bkt_q; hd_wd = '0; hd_ra = mrsp.bucket;
    k_we = 1'b0; k_wa = newn_q; k_wd = req_q.key;
    v_we = 1'b0; v_wa = newn_q; v_wd = req_q.payload & PayMask;
    l_we = 1'b0; l_wa = newn_q; l_wd = '0;
    n_ra = pos_q;
    case (state_q)
      S_CLEAR: begin
        hd_we = 1'b1; hd_wa = clr_q;
      end
      S_IDLE:  mreq.start = start;
      S_CMP: begin
        if (hit) begin
          case (req_q.operation)
            OP_UPSERT, OP_UPDATE: begin
              v_we = 1'b1; v_wa = pos_q;
            end
            OP_DELETE: begin
              // unlink: predecessor (or head) takes the successor
              if (prev_q == '0) begin
                hd_we = 1'b1; hd_wd = l_rd;
              end else begin
                l_we = 1'b1; l_wa = prev_q; l_wd = l_rd;
              end
            end
            default: ;
          endcase
        end
      end
      S_FREE: begin
        // push the unlinked node on the free list
        l_we = 1'b1; l_wa = pos_q; l_wd = free_q;
      end
      S_FREERD: n_ra = free_q;
      S_ALLOC: begin
        // write the new node; an empty chain gets it as head
        k_we = 1'b1;
        v_we = 1'b1;
        l_we = 1'b1;
        if (prev_q == '0) begin
          hd_we = 1'b1; hd_wd = newn_q;
        end
      end
      S_TAIL: begin
        l_we = 1'b1; l_wa = prev_q; l_wd = newn_q;
      end
      default: ;
    endcase
  end

  // main sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      bcnt_q  <= CfgW'(Buckets);
      free_q  <= '0;
      fresh_q <= (NodeW+1)'(1);
      done_q  <= 1'b0;
      steps_q <= '0;
      req_q   <= '0;
      rsp_q   <= '0;
      bkt_q   <= '0;
      pos_q   <= '0;
      prev_q  <= '0;
      newn_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) bcnt_q <= cfg_wdata_i;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + BktW'(1);
          if (clr_q == BktW'(Buckets - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            req_q   <= req_i;
            rsp_q   <= '0;
            state_q <= (req_i.operation > OP_DELETE) ? S_DONE : S_MOD;
          end
        end
        S_MOD: begin
          if (mrsp.done) begin
            bkt_q   <= mrsp.bucket;
            state_q <= S_HEAD;
          end
        end
        S_HEAD: begin
          pos_q   <= hd_rd;
          prev_q  <= '0;
          steps_q <= '0;
          state_q <= S_NODE;
        end
        S_NODE: begin
          // chain end or bound: miss
          if (pos_q == '0 || steps_q == (NodeW+1)'(Nodes)) begin
            case (req_q.operation)
              OP_INSERT, OP_UPSERT: begin
                if (free_q != '0) state_q <= S_FREERD;
                else if (fresh_q < (NodeW+1)'(Nodes)) begin
                  newn_q  <= fresh_q[NodeW-1:0];
                  fresh_q <= fresh_q + (NodeW+1)'(1);
                  state_q <= S_ALLOC;
                end else begin
                  rsp_q.status <= ST_FULL;
                  state_q <= S_DONE;
                end
              end
              default: begin
                rsp_q.status <= ST_NOT_FOUND;
                state_q <= S_DONE;
              end
            endcase
          end else state_q <= S_CMP;
        end
        S_CMP: begin
          if (hit) begin
            case (req_q.operation)
              OP_INSERT: rsp_q.status <= ST_PRESENT;
              OP_READ:   rsp_q.read_payload <= v_rd & PayMask;
              default: ;
            endcase
            state_q <= (req_q.operation == OP_DELETE) ? S_FREE : S_DONE;
          end else begin
            prev_q  <= pos_q;
            pos_q   <= l_rd;
            steps_q <= steps_q + (NodeW+1)'(1);
            state_q <= S_NODE;
          end
        end
        S_FREE: begin
          free_q  <= pos_q;
          state_q <= S_DONE;
        end
        S_FREERD:   state_q <= S_FREEWAIT;
        S_FREEWAIT: begin
          newn_q  <= free_q;
          free_q  <= l_rd;
          state_q <= S_ALLOC;
        end
        S_ALLOC:    state_q <= (prev_q == '0) ? S_DONE : S_TAIL;
        S_TAIL:     state_q <= S_DONE;
        S_DONE: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `CHTE_ASSERT(a_done_pulse, clk_i, rst_ni, done_q |=> !done_q, "done longer than one cycle")
  `CHTE_ASSERT(a_done_idle, clk_i, rst_ni, done_q |-> state_q == S_IDLE, "done while busy")
  `CHTE_ASSERT(a_fresh_rng, clk_i, rst_ni, fresh_q <= (NodeW+1)'(Nodes), "fresh overflow")
endmodule

FILE: verif/testbench.sv
// Testbench for the chained hash table engine: directed table and random traffic
`timescale 1ns / 1ps
module testbench;
  import chte_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic done_o;
  rsp_t rsp_o;
  logic cfg_we_i = 1'b0;
  logic [CfgW-1:0] cfg_wdata_i = '0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  chained_hash_table_engine_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // ---- table shadow: heads, node pool, free list, fresh counter, bucket count
  logic [NodeW-1:0] shadow_head [Buckets];
  logic [63:0]      shadow_key  [Nodes];
  logic [63:0]      shadow_val  [Nodes];
  logic [NodeW-1:0] shadow_link [Nodes];
  logic [NodeW-1:0] shadow_free;
  logic [NodeW:0]   shadow_fresh;
  logic [CfgW-1:0]  shadow_bkt_cnt;

  // expected responses, in request order
  rsp_t pend_mem [64];
  int   pend_wr = 0;
  int   pend_rd = 0;
  int   mismatches = 0;

  // Apply one request to the shadow table and return the response it should get.
  function automatic rsp_t table_apply(input req_t r);
    rsp_t o;
    logic [CfgW-1:0]  n;
    logic [BktW-1:0]  b;
    logic [NodeW-1:0] pos, prev, at, nd;
    int unsigned steps;
    logic hit;
    logic got;
    o = '0;
    n = shadow_bkt_cnt;
    if (n == '0) n = CfgW'(1);
    if (n > CfgW'(Buckets)) n = CfgW'(Buckets);
    b = BktW'(r.key[31:0] % 32'(n));
    if (r.operation > OP_DELETE) return o;   // unknown op: no effect, ok
    // chain walk: at is the hit node, prev the node before it / the tail on a miss
    pos = shadow_head[b];
    prev = '0;
    steps = 0;
    hit = 1'b0;
    at = '0;
    while (pos != '0 && steps < Nodes && !hit) begin
      if (shadow_key[pos] == r.key) begin
        hit = 1'b1;
        at = pos;
      end else begin
        prev = pos;
        pos = shadow_link[pos];
        steps++;
      end
    end
    case (op_e'(r.operation))
      OP_READ: begin
        if (hit) o.read_payload = shadow_val[at];
        else o.status = ST_NOT_FOUND;
      end
      OP_UPDATE: begin
        if (hit) shadow_val[at] = r.payload;
        else o.status = ST_NOT_FOUND;
      end
      OP_DELETE: begin
        if (hit) begin
          if (prev != '0) shadow_link[prev] = shadow_link[at];
          else shadow_head[b] = shadow_link[at];
          shadow_link[at] = shadow_free;
          shadow_free = at;
        end else o.status = ST_NOT_FOUND;
      end
      default: begin  // insert / upsert
        if (hit) begin
          if (r.operation == OP_INSERT) o.status = ST_PRESENT;
          else shadow_val[at] = r.payload;
        end else begin
          // allocate from free list first, then fresh counter
          got = 1'b1;
          nd = '0;
          if (shadow_free != '0) begin
            nd = shadow_free;
            shadow_free = shadow_link[nd];
          end else if (shadow_fresh < Nodes) begin
            nd = shadow_fresh[NodeW-1:0];
            shadow_fresh++;
          end else got = 1'b0;
          if (got) begin
            shadow_key[nd] = r.key;
            shadow_val[nd] = r.payload;
            shadow_link[nd] = '0;
            if (prev != '0) shadow_link[prev] = nd;
            else shadow_head[b] = nd;
          end else o.status = ST_FULL;
        end
      end
    endcase
    return o;
  endfunction

  // ---- sender: bursts of random length with random gaps
  int burst_left = 0;

  // Present one request from the falling edge; returns the predicted response.
  task automatic issue(input req_t r, input logic has_typed, input rsp_t typed,
                       output rsp_t predicted);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    start = 1'b1;
    req_i = r;
    do @(posedge clk_i); while (busy);   // accepted at this edge
    predicted = table_apply(r);
    pend_mem[pend_wr % 64] = has_typed ? typed : predicted;
    pend_wr++;
    @(negedge clk_i);
    start = 1'b0;
  endtask

  // Drain all responses, let the engine settle, then write the bucket count.
  task automatic write_bucket_count(input logic [CfgW-1:0] v);
    start = 1'b0;
    while (pend_wr != pend_rd) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    while (busy) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    shadow_bkt_cnt = v;
  endtask

  // ---- result checker
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && done_o) begin
      if (pend_wr == pend_rd) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %h", rsp_o);
      end else begin
        want = pend_mem[pend_rd % 64];
        pend_rd++;
        if (rsp_o.status !== want.status || rsp_o.read_payload !== want.read_payload) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status exp %0d got %0d, payload exp %h got %h",
                     want.status, rsp_o.status, want.read_payload, rsp_o.read_payload);
        end
      end
    end
  end

  // ---- directed table
  typedef struct {
    op_e         op;
    logic [63:0] key;
    logic [63:0] payload;
    logic        has_typed;
    rsp_t        typed;
  } vec_t;

  function automatic vec_t row(op_e op, logic [63:0] k, logic [63:0] p,
                               logic ht = 1'b0, status_e s = ST_OK, logic [63:0] rd = '0);
    vec_t v;
    v.op = op; v.key = k; v.payload = p; v.has_typed = ht;
    v.typed.status = s; v.typed.read_payload = rd;
    return v;
  endfunction

  vec_t dir_tab [32];
  int   dir_cnt = 0;

  task automatic add_row(input vec_t v);
    dir_tab[dir_cnt] = v;
    dir_cnt++;
  endtask

  logic [63:0] key_pool[16];

  function automatic req_t random_req();
    req_t r;
    int unsigned w;
    w = $urandom_range(0, 99);
    if (w < 25) r.operation = OP_INSERT;
    else if (w < 45) r.operation = OP_READ;
    else if (w < 60) r.operation = OP_UPSERT;
    else if (w < 75) r.operation = OP_UPDATE;
    else if (w < 95) r.operation = OP_DELETE;
    else r.operation = 3'($urandom_range(5, 7));
    // mostly pooled keys so chains build up; some fresh random ones
    r.key = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom}
                                        : key_pool[$urandom_range(0, 15)];
    r.payload = {$urandom, $urandom};
    return r;
  endfunction

  initial begin
    rsp_t got;
    req_t r;
    logic [CfgW-1:0] bkt_settings[5];

    foreach (shadow_head[i]) shadow_head[i] = '0;
    shadow_free = '0;
    shadow_fresh = 1;
    shadow_bkt_cnt = Buckets;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // extremes, every op, chain head/middle delete, unknown ops
    add_row(row(OP_READ,   64'd0, 64'd0, 1'b1, ST_NOT_FOUND));
    add_row(row(OP_DELETE, 64'd5, 64'd0, 1'b1, ST_NOT_FOUND));
    add_row(row(OP_UPDATE, 64'd5, '1,    1'b1, ST_NOT_FOUND));
    add_row(row(OP_INSERT, 64'd0, '1,    1'b1, ST_OK));
    add_row(row(OP_INSERT, '1,    64'd0, 1'b1, ST_OK));
    add_row(row(OP_INSERT, 64'd0, 64'd7, 1'b1, ST_PRESENT));
    add_row(row(OP_READ,   64'd0, 64'd0, 1'b1, ST_OK, '1));
    add_row(row(OP_READ,   '1,    64'd9, 1'b1, ST_OK, 64'd0));
    add_row(row(OP_UPSERT, '1,    64'h5555_5555_5555_5555));
    add_row(row(OP_UPSERT, 64'd1, 64'hAAAA_AAAA_AAAA_AAAA));
    add_row(row(OP_READ,   '1,    64'd0));
    add_row(row(OP_UPDATE, 64'd0, 64'h8000_0000_0000_0001));
    add_row(row(OP_READ,   64'd0, 64'd0));
    add_row(row(OP_INSERT, 64'd1024, 64'd11));
    add_row(row(OP_INSERT, 64'hFFFF_FFFF_0000_0800, 64'd12));
    add_row(row(OP_DELETE, 64'd1024, 64'd0));          // middle of chain
    add_row(row(OP_DELETE, 64'd0, 64'd0));             // chain head
    add_row(row(OP_READ,   64'hFFFF_FFFF_0000_0800, 64'd0));
    add_row(row(OP_INSERT, 64'd2048, 64'd13));         // reuses freed node
    add_row(row(OP_READ,   64'd0, 64'd0, 1'b1, ST_NOT_FOUND));
    add_row(row(op_e'(3'd5), 64'd1, '1, 1'b1, ST_OK));
    add_row(row(op_e'(3'd6), '1,    '1, 1'b1, ST_OK));
    add_row(row(op_e'(3'd7), 64'd1, '1, 1'b1, ST_OK));

    write_bucket_count(11'd1024);
    for (int i = 0; i < dir_cnt; i++) begin
      r.operation = dir_tab[i].op;
      r.key = dir_tab[i].key;
      r.payload = dir_tab[i].payload;
      issue(r, dir_tab[i].has_typed, dir_tab[i].typed, got);
    end

    // key pool: low words that collide under small bucket counts
    foreach (key_pool[i])
      key_pool[i] = {$urandom, (i < 8) ? 32'(i * 1024) : $urandom};

    // random traffic across bucket counts: single, zero, saturated, odd, random
    bkt_settings[0] = 11'd1;
    bkt_settings[1] = 11'd0;
    bkt_settings[2] = 11'd2047;
    bkt_settings[3] = 11'd7;
    bkt_settings[4] = 11'($urandom_range(2, 1024));
    foreach (bkt_settings[s]) begin
      write_bucket_count(bkt_settings[s]);
      repeat (106) issue(random_req(), 1'b0, '0, got);
    end

    // delete an absent key, then insert one and read it back
    write_bucket_count(11'd1024);
    r = '0;
    r.operation = OP_DELETE;
    r.key = {32'hA5A5_0003, 32'd3};
    issue(r, 1'b0, '0, got);
    r.operation = OP_INSERT;
    r.key = {32'hA5A5_FFFF, 32'd3};
    r.payload = '1;
    issue(r, 1'b0, '0, got);
    r.operation = OP_READ;
    issue(r, 1'b0, '0, got);

    start = 1'b0;
    while (pend_wr != pend_rd) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (mismatches == 0 && pend_wr == pend_rd) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #100ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule

FILE: chained_hash_table_engine_core.f
+incdir+rtl
rtl/chte_pkg.sv
rtl/chte_ram.sv
rtl/chte_mod.sv
rtl/chained_hash_table_engine_core.sv
verif/testbench.sv
